// ----- hdl/cosine_top_n_neighbour_search_macros.svh -----
// ---------------------------------------------------------------------------
// Assertion macros for the neighbour search block
// Clocked on clk, disabled while rst is high.
// ---------------------------------------------------------------------------
`ifndef COSINE_TOP_N_NEIGHBOUR_SEARCH_MACROS_SVH
`define COSINE_TOP_N_NEIGHBOUR_SEARCH_MACROS_SVH

// cond must hold at every clock edge
`define CTNNS_ASSERT_ALWAYS(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// cons must hold at the edge after ante
`define CTNNS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- hdl/ctnns_pkg.sv -----
// ---------------------------------------------------------------------------
// ctnns_pkg
// Constants shared by the cosine neighbour search block.
// ---------------------------------------------------------------------------
package ctnns_pkg;

  localparam int MAX_WORDS = 1024;
  localparam int MAX_DIMS  = 256;
  localparam int TOP       = 40;

  localparam int WORD_W = $clog2(MAX_WORDS);
  localparam int DIM_W  = $clog2(MAX_DIMS);
  localparam int ADDR_W = WORD_W + DIM_W;
  localparam int CNT_W  = $clog2(TOP + 1);

  localparam logic signed [31:0] MINUS_ONE = -32'sd1073741824;

  localparam logic REG_WORDS = 1'b0;
  localparam logic REG_DIMS  = 1'b1;

endpackage

// ----- hdl/cosine_top_n_neighbour_search.sv -----
// ---------------------------------------------------------------------------
// cosine_top_n_neighbour_search
// Row store with in-place normalization and a top-N cosine neighbour query.
// ---------------------------------------------------------------------------
// Load: transactions are taken while idle; the row's last component starts
//   the sum of squares and square root, then a divide for every component
//   (cut short when the quotient clamps).
// Query: copies the query row, then scores each candidate row through the
//   single store read port, then gives one result per cycle while not stalled.
// Reset sets the word and dim registers to their maximums, clears control and
//   the best list; the row store is not cleared and holds undefined data until written.
module cosine_top_n_neighbour_search (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [2:0]                    paddr,
  input  logic [31:0]                   pwdata,
  output logic [31:0]                   prdata,
  output logic                          pready,
  input  logic                          item_valid,
  output logic                          item_stall,
  input  logic                          mode,
  input  logic [ctnns_pkg::WORD_W-1:0]  word_index,
  input  logic [ctnns_pkg::DIM_W-1:0]   dim_index,
  input  logic signed [15:0]            component_value,
  output logic                          result_valid,
  input  logic                          result_stall,
  output logic                          found,
  output logic [5:0]                    rank,
  output logic [ctnns_pkg::WORD_W-1:0]  neighbour_index,
  output logic signed [31:0]            score,
  output logic                          last
);
  import ctnns_pkg::*;

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SUM   = 4'd1;
  localparam logic [3:0] S_SQRT  = 4'd2;
  localparam logic [3:0] S_NRD   = 4'd3;
  localparam logic [3:0] S_NDAT  = 4'd4;
  localparam logic [3:0] S_NDIV  = 4'd5;
  localparam logic [3:0] S_NWR   = 4'd6;
  localparam logic [3:0] S_QCOPY = 4'd7;
  localparam logic [3:0] S_QNEXT = 4'd8;
  localparam logic [3:0] S_QDOT  = 4'd9;
  localparam logic [3:0] S_QINS  = 4'd10;
  localparam logic [3:0] S_EMIT  = 4'd11;

  logic [3:0] state;

  logic [10:0] words_in_use;
  logic [8:0]  dims_in_use;
  logic [10:0] words_eff;
  logic [8:0]  dims_eff;

  logic [15:0] row_store [1 << ADDR_W];
  logic [15:0] qbuf [MAX_DIMS];
  logic [15:0] mem_rdata;
  logic [15:0] qbuf_rdata;
  logic [ADDR_W-1:0] mem_raddr;
  logic [ADDR_W-1:0] mem_waddr;
  logic [15:0] mem_wdata;
  logic        mem_we;

  logic [DIM_W:0]        ia;
  logic                  rv;
  logic                  pv;
  logic [DIM_W-1:0]      ra_d;
  logic signed [31:0]    prod;
  logic signed [39:0]    acc;
  logic [WORD_W-1:0]     nrow;
  logic [WORD_W-1:0]     qword;
  logic [10:0]           c;
  logic                  issue;
  logic                  pipe_done;

  logic [63:0] sx;
  logic [63:0] sres;
  logic [63:0] sbit;
  logic [63:0] ssum;
  logic [4:0]  step;
  logic [31:0] lenr;

  logic        neg;
  logic [15:0] mag;
  logic [46:0] rem;
  logic [46:0] dv;
  logic [14:0] q;

  logic signed [31:0] bs [TOP];
  logic [WORD_W-1:0]  br [TOP];
  logic [TOP-1:0]     ins;
  logic signed [31:0] cand_score;
  logic [CNT_W-1:0]   cnt;
  logic [5:0]         rk;

  logic item_acc;
  logic out_free;
  logic cfg_wr;

  assign pready   = 1'b1;
  assign cfg_wr   = psel && penable && pwrite;
  assign item_acc = item_valid && !item_stall;
  assign item_stall = rst || (state != S_IDLE);
  assign out_free = !result_valid || !result_stall;

  assign words_eff = (words_in_use > 11'(MAX_WORDS)) ? 11'(MAX_WORDS) : words_in_use;
  assign dims_eff  = (dims_in_use > 9'(MAX_DIMS)) ? 9'(MAX_DIMS) : dims_in_use;

  always_ff @(posedge clk) begin
    if (rst) begin
      words_in_use <= 11'd1024;
      dims_in_use  <= 9'd256;
    end else if (cfg_wr) begin
      unique case (paddr[2])
        REG_WORDS: words_in_use <= pwdata[10:0];
        REG_DIMS:  dims_in_use  <= pwdata[8:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_WORDS: prdata = {21'd0, words_in_use};
      REG_DIMS:  prdata = {23'd0, dims_in_use};
      default:   prdata = 32'd0;
    endcase
  end

  // store ports
  always_comb begin
    unique case (state)
      S_QCOPY: mem_raddr = {qword, ia[DIM_W-1:0]};
      S_QDOT:  mem_raddr = {c[WORD_W-1:0], ia[DIM_W-1:0]};
      default: mem_raddr = {nrow, ia[DIM_W-1:0]};
    endcase
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = {nrow, ia[DIM_W-1:0]};
    mem_wdata = neg ? 16'(-{1'b0, q}) : {1'b0, q};
    if (state == S_IDLE) begin
      mem_we    = item_acc && !mode && ({1'b0, dim_index} < dims_eff);
      mem_waddr = {word_index, dim_index};
      mem_wdata = component_value;
    end else if (state == S_NWR) begin
      mem_we = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (mem_we) row_store[mem_waddr] <= mem_wdata;
    mem_rdata <= row_store[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (state == S_QCOPY && rv) qbuf[ra_d] <= mem_rdata;
    qbuf_rdata <= qbuf[ia[DIM_W-1:0]];
  end

  assign issue = (state == S_SUM || state == S_QCOPY || state == S_QDOT) && (ia < dims_eff);
  assign pipe_done = !issue && !rv && !pv;

  assign ssum = sres + sbit;

  always_comb begin
    if (acc > 40'sh007FFFFFFF)       cand_score = 32'sh7FFFFFFF;
    else if (acc < -40'sh0080000000) cand_score = 32'sh80000000;
    else                             cand_score = acc[31:0];
  end

  always_comb begin
    for (int k = 0; k < TOP; k++) ins[k] = cand_score > bs[k];
  end

  // datapath and control
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      rv           <= 1'b0;
      pv           <= 1'b0;
      cnt          <= '0;
      rk           <= '0;
      result_valid <= 1'b0;
      for (int k = 0; k < TOP; k++) begin
        bs[k] <= MINUS_ONE;
        br[k] <= '0;
      end
    end else begin
      rv   <= issue;
      ra_d <= ia[DIM_W-1:0];
      pv   <= rv && (state != S_QCOPY);
      prod <= $signed(mem_rdata) *
              ((state == S_SUM) ? $signed(mem_rdata) : $signed(qbuf_rdata));
      if (issue) ia <= ia + 1'b1;
      if (pv) acc <= acc + 40'(prod);
      if (result_valid && !result_stall && state != S_EMIT) result_valid <= 1'b0;

      unique case (state)
        S_IDLE: begin
          if (item_acc && !mode) begin
            if ({1'b0, dim_index} == dims_eff - 1'b1) begin
              nrow  <= word_index;
              ia    <= '0;
              acc   <= '0;
              state <= S_SUM;
            end
          end else if (item_acc) begin
            qword <= word_index;
            cnt   <= '0;
            rk    <= '0;
            ia    <= '0;
            c     <= '0;
            for (int k = 0; k < TOP; k++) begin
              bs[k] <= MINUS_ONE;
              br[k] <= '0;
            end
            state <= ({1'b0, word_index} >= words_eff) ? S_EMIT : S_QCOPY;
          end
        end
        S_SUM: begin
          if (pipe_done) begin
            sx    <= {8'd0, acc, 16'd0};
            sres  <= '0;
            sbit  <= 64'd1 << 62;
            step  <= 5'd31;
            ia    <= '0;
            state <= S_SQRT;
          end
        end
        S_SQRT: begin
          if (sx >= ssum) begin
            sx   <= sx - ssum;
            sres <= (sres >> 1) + sbit;
          end else begin
            sres <= sres >> 1;
          end
          sbit <= sbit >> 2;
          if (step == '0) state <= S_NRD;
          else step <= step - 1'b1;
        end
        S_NRD: begin
          if (step == '0 && ia == '0) lenr <= sres[31:0];
          if (step == '0 && ia == '0 && sres == '0) begin
            state <= S_IDLE;
          end else begin
            step  <= 5'd1;
            state <= S_NDAT;
          end
        end
        S_NDAT: begin
          neg <= mem_rdata[15];
          mag <= mem_rdata[15] ? 16'(-mem_rdata) : mem_rdata;
          state <= S_NDIV;
          step  <= 5'd15;
        end
        S_NDIV: begin
          if (step == 5'd15) begin
            if ({8'd0, mag, 8'd0} >= lenr) begin
              q     <= 15'h7FFF;
              state <= S_NWR;
            end else begin
              rem  <= {8'd0, mag, 23'd0};
              dv   <= {1'b0, lenr, 14'd0};
              step <= 5'd14;
            end
          end else begin
            if (rem >= dv) begin
              rem <= rem - dv;
              q   <= {q[13:0], 1'b1};
            end else begin
              q   <= {q[13:0], 1'b0};
            end
            dv <= dv >> 1;
            if (step == '0) state <= S_NWR;
            else step <= step - 1'b1;
          end
        end
        S_NWR: begin
          ia <= ia + 1'b1;
          if (ia + 1'b1 == dims_eff) state <= S_IDLE;
          else state <= S_NRD;
        end
        S_QCOPY: begin
          if (pipe_done) state <= S_QNEXT;
        end
        S_QNEXT: begin
          if (c == words_eff) begin
            state <= S_EMIT;
          end else if (c[WORD_W-1:0] == qword) begin
            c <= c + 1'b1;
          end else begin
            ia    <= '0;
            acc   <= '0;
            state <= S_QDOT;
          end
        end
        S_QDOT: begin
          if (pipe_done) state <= S_QINS;
        end
        S_QINS: begin
          for (int k = 0; k < TOP; k++) begin
            if (k > 0 && ins[(k > 0) ? k - 1 : 0]) begin
              bs[k] <= bs[(k > 0) ? k - 1 : 0];
              br[k] <= br[(k > 0) ? k - 1 : 0];
            end else if (ins[k]) begin
              bs[k] <= cand_score;
              br[k] <= c[WORD_W-1:0];
            end
          end
          if (ins[TOP-1] && cnt != CNT_W'(TOP)) cnt <= cnt + 1'b1;
          c     <= c + 1'b1;
          state <= S_QNEXT;
        end
        S_EMIT: begin
          if (out_free) begin
            result_valid <= 1'b1;
            if (cnt == '0) begin
              found           <= 1'b0;
              rank            <= '0;
              neighbour_index <= '0;
              score           <= '0;
              last            <= 1'b1;
              state           <= S_IDLE;
            end else begin
              found           <= 1'b1;
              rank            <= rk;
              neighbour_index <= br[0];
              score           <= bs[0];
              last            <= (cnt == CNT_W'(1));
              for (int k = 0; k < TOP - 1; k++) begin
                bs[k] <= bs[k + 1];
                br[k] <= br[k + 1];
              end
              bs[TOP-1] <= MINUS_ONE;
              br[TOP-1] <= '0;
              cnt <= cnt - 1'b1;
              rk  <= rk + 1'b1;
              if (cnt == CNT_W'(1)) state <= S_IDLE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hdl/ctnns_checker.sv -----
// ---------------------------------------------------------------------------
// ctnns_checker
// Port-level checks for the neighbour search block, bound to the top level.
// ---------------------------------------------------------------------------
`include "cosine_top_n_neighbour_search_macros.svh"

module ctnns_checker (
  input logic                         clk,
  input logic                         rst,
  input logic                         item_valid,
  input logic                         item_stall,
  input logic                         mode,
  input logic                         result_valid,
  input logic                         result_stall,
  input logic                         found,
  input logic [5:0]                   rank,
  input logic [ctnns_pkg::WORD_W-1:0] neighbour_index,
  input logic signed [31:0]           score,
  input logic                         last
);
  import ctnns_pkg::*;

  `CTNNS_ASSERT_NEXT(a_out_hold, result_valid && result_stall, result_valid && $stable(score) && $stable(neighbour_index) && $stable(last), "result changed while stalled")
  `CTNNS_ASSERT_NEXT(a_query_busy, item_valid && !item_stall && mode, item_stall, "query transaction did not stall input")
  `CTNNS_ASSERT_ALWAYS(a_mid_list, !(result_valid && !last) || item_stall, "input open before last result")
  `CTNNS_ASSERT_ALWAYS(a_not_found, !(result_valid && !found) || (last && rank == 6'd0 && score == 32'sd0), "bad not-found result")

endmodule

bind cosine_top_n_neighbour_search ctnns_checker u_ctnns_checker (.*);
